// File: rtl/ildf_pkg.sv
// Shared constants for the IIR lowpass decimate-by-four block.
// Coefficients are Q4.28; used by the top level and its port checker.
// No dependencies.
package ildf_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int DATA_W      = 32;
	localparam int ACC_W       = 64;
	localparam int TAPS        = 7;
	localparam int HIST        = TAPS - 1;
	localparam int TERMS       = 2 * TAPS - 1;
	localparam int DECIMATION  = 4;
	localparam int IN_SHIFT    = 29 - SAMPLE_BITS;
	localparam int NUM_HIST    = 3;
	localparam int MEM_DEPTH   = 24;

	typedef logic signed [DATA_W-1:0] coef_t;

	localparam coef_t COEF_B [TAPS] = '{
		32'sd282299, 32'sd1693796, 32'sd4234489, 32'sd5645986,
		32'sd4234489, 32'sd1693796, 32'sd282299
	};

	localparam coef_t COEF_A [TAPS] = '{
		32'sd268435456, -32'sd799543039, 32'sd1110270789, -32'sd875036311,
		32'sd407291439, -32'sd104989732, 32'sd11638553
	};

	localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

endpackage

// File: rtl/iir_lowpass_decimate_by_four.sv
// Two cascaded 6th-order IIR lowpass sections with decimation by four.
// One shared 32x32 MAC walks the history memory; depends on ildf_pkg.
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+-------------------------
//  in      | in_valid, sample_in, start_req   | in_valid & !in_stall
//  out     | out_valid, sample_out, saturated | out_valid & !out_stall
//  cfg     | cfg_we, cfg_wdata                | cfg_we
//
// A filtered sample makes two passes of 13 MAC terms through the single
// memory read port and the read, multiply and accumulate pipe, then three
// history write-backs; at phase zero it then loads the output register. A
// bypassed sample goes straight to it. The next input is taken while a result
// waits in the output register; a held output stalls only the next load.
// Reset clears control state and all history valid bits; no clearing pass.
module iir_lowpass_decimate_by_four
	import ildf_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          start_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          saturated,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_WB    = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	localparam logic [1:0] RGN_X  = 2'd0;
	localparam logic [1:0] RGN_Y1 = 2'd1;
	localparam logic [1:0] RGN_Y2 = 2'd2;

	localparam int TERM_W = $clog2(TERMS);
	localparam int SLOT_W = $clog2(HIST);
	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int PH_W   = $clog2(DECIMATION);

	logic [2:0]              state_q;
	logic                    dec_en_q;
	logic                    stage_q;
	logic [TERM_W-1:0]       term_q;
	logic [1:0]              wb_q;
	logic [SLOT_W-1:0]       ptr_q;
	logic [PH_W-1:0]         phase_q;
	logic [HIST-1:0]         valid_q [NUM_HIST];

	logic signed [DATA_W-1:0] cur_q;
	logic signed [DATA_W-1:0] y1_q;
	logic signed [DATA_W-1:0] y2_q;
	logic [ACC_W-1:0]         acc_q;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic                     res_sat_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                     out_sat_q;
	logic                     out_valid_q;

	logic [DATA_W-1:0]        mem [MEM_DEPTH];
	logic [DATA_W-1:0]        rdata_s1;

	logic                     vld_s1, neg_s1, tap0_s1, hit_s1;
	coef_t                    coef_s1;
	logic                     vld_s2, neg_s2;
	logic signed [ACC_W-1:0]  prod_s2;

	logic                     in_xfer;
	logic                     issue;
	logic                     last_term;
	logic [TERM_W-1:0]        term_p1;
	logic [2:0]               tap_j;
	logic                     term_even;
	logic [1:0]               rd_region;
	logic [3:0]               slot_sum;
	logic [SLOT_W-1:0]        rd_slot;
	logic [ADDR_W-1:0]        raddr;
	coef_t                    rd_coef;
	logic                     wr_en;
	logic [ADDR_W-1:0]        waddr;
	logic [DATA_W-1:0]        wdata;
	logic                     drained;
	logic signed [DATA_W-1:0] stage_y;
	logic signed [DATA_W-1:0] opnd;
	logic                     out_load;
	logic signed [SAMPLE_BITS-1:0] rnd_val;
	logic                     rnd_sat;
	logic [ACC_W-1:0]         acc_rnd;
	logic [DATA_W:0]          y2_rnd;
	logic [DATA_W-IN_SHIFT:0] y2_hi;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;
	assign saturated  = out_sat_q;

	// term 0 uses the tap register; odd terms read the feed-forward history,
	// even terms the feedback history with the a coefficient subtracted
	assign issue     = (state_q == ST_RUN);
	assign last_term = (term_q == TERM_W'(TERMS - 1));
	assign term_p1   = term_q + 1'b1;
	assign tap_j     = term_p1[3:1];
	assign term_even = !term_q[0];
	assign rd_region = {1'b0, stage_q} + {1'b0, term_even};
	assign slot_sum  = {1'b0, ptr_q} + 4'(HIST) - {1'b0, tap_j};
	assign rd_slot   = (slot_sum >= 4'(HIST)) ? 3'(slot_sum - 4'(HIST)) : slot_sum[2:0];
	assign raddr     = {rd_region, rd_slot};

	always_comb begin
		if (term_q == '0) begin
			rd_coef = COEF_B[0];
		end else if (term_even) begin
			rd_coef = COEF_A[tap_j];
		end else begin
			rd_coef = COEF_B[tap_j];
		end
	end

	// write-back: input, first stage, second stage, all at the current slot
	assign wr_en = (state_q == ST_WB);
	assign waddr = {wb_q, ptr_q};
	always_comb begin
		case (wb_q)
			RGN_X:   wdata = cur_q;
			RGN_Y1:  wdata = y1_q;
			default: wdata = y2_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	// MAC pipe: read, multiply, accumulate
	assign opnd = tap0_s1 ? (stage_q ? y1_q : cur_q)
	            : (hit_s1 ? $signed(rdata_s1) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= term_even && (term_q != '0);
		tap0_s1 <= (term_q == '0);
		hit_s1  <= valid_q[rd_region][rd_slot];
		coef_s1 <= rd_coef;
		neg_s2  <= neg_s1;
		prod_s2 <= coef_s1 * opnd;
	end

	assign drained = !vld_s1 && !vld_s2;

	// round half up to Q4.28 and clip to 32 bits
	always_comb begin
		acc_rnd = acc_q + (ACC_W'(1) << 27);
		if (acc_rnd[ACC_W-1:59] != {5{acc_rnd[59]}}) begin
			stage_y = acc_rnd[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
			                           : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			stage_y = $signed(acc_rnd[59:28]);
		end
	end

	// round half up to Q1.15 and clip to the sample range
	always_comb begin
		y2_rnd = {y2_q[DATA_W-1], y2_q} + ((DATA_W+1)'(1) << (IN_SHIFT - 1));
		y2_hi  = y2_rnd[DATA_W:IN_SHIFT];
		if (y2_hi[DATA_W-IN_SHIFT:SAMPLE_BITS-1] !=
		    {(DATA_W-IN_SHIFT-SAMPLE_BITS+2){y2_hi[SAMPLE_BITS-1]}}) begin
			rnd_sat = 1'b1;
			rnd_val = y2_hi[DATA_W-IN_SHIFT] ? OUT_MIN : OUT_MAX;
		end else begin
			rnd_sat = 1'b0;
			rnd_val = $signed(y2_hi[SAMPLE_BITS-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_q <= {{(DATA_W-SAMPLE_BITS-IN_SHIFT){sample_in[SAMPLE_BITS-1]}},
			          sample_in, {IN_SHIFT{1'b0}}};
			res_q     <= sample_in;
			res_sat_q <= 1'b0;
			acc_q     <= '0;
		end else if (state_q == ST_DRAIN && drained) begin
			acc_q <= '0;
			if (!stage_q) begin
				y1_q <= stage_y;
			end else begin
				y2_q <= stage_y;
			end
		end else if (vld_s2) begin
			acc_q <= neg_s2 ? acc_q - $unsigned(prod_s2) : acc_q + $unsigned(prod_s2);
		end
		if (state_q == ST_WB && wb_q == RGN_Y2) begin
			res_q     <= rnd_val;
			res_sat_q <= rnd_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dec_en_q <= 1'b1;
			stage_q  <= 1'b0;
			term_q   <= '0;
			wb_q     <= '0;
			ptr_q    <= '0;
			phase_q  <= '0;
			for (int r = 0; r < NUM_HIST; r++) begin
				valid_q[r] <= '0;
			end
		end else begin
			if (cfg_we) begin
				dec_en_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (start_req) begin
							ptr_q   <= '0;
							phase_q <= '0;
							for (int r = 0; r < NUM_HIST; r++) begin
								valid_q[r] <= '0;
							end
						end
						stage_q <= 1'b0;
						term_q  <= '0;
						state_q <= dec_en_q ? ST_RUN : ST_EMIT;
					end
				end
				ST_RUN: begin
					if (last_term) begin
						state_q <= ST_DRAIN;
					end else begin
						term_q <= term_p1;
					end
				end
				ST_DRAIN: begin
					if (drained) begin
						term_q <= '0;
						if (!stage_q) begin
							stage_q <= 1'b1;
							state_q <= ST_RUN;
						end else begin
							wb_q    <= RGN_X;
							state_q <= ST_WB;
						end
					end
				end
				ST_WB: begin
					valid_q[wb_q][ptr_q] <= 1'b1;
					if (wb_q == RGN_Y2) begin
						ptr_q   <= (ptr_q == SLOT_W'(HIST - 1)) ? '0 : ptr_q + 1'b1;
						phase_q <= (phase_q == PH_W'(DECIMATION - 1)) ? '0 : phase_q + 1'b1;
						// drop the sample unless the phase was zero
						state_q <= (phase_q == '0) ? ST_EMIT : ST_IDLE;
					end else begin
						wb_q <= wb_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: load when empty or being taken this cycle
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_q;
			out_sat_q  <= res_sat_q;
		end
	end

endmodule

// File: rtl/ildf_checker.sv
// Port-level checks for the IIR lowpass decimate-by-four block.
// Attached to the top level by the bind below; depends on ildf_pkg.
module ildf_checker
	import ildf_pkg::*;
(
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] sample_out,
	input logic                          saturated
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(saturated))
		else $error("output changed while stalled");

	// a clipped result sits on one of the range limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (sample_out == OUT_MAX || sample_out == OUT_MIN))
		else $error("saturated flag without a limit value");

	// every accepted item keeps the block busy in the cycle after it is taken
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// a new result only appears while the input side was busy with its item
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in flight");

endmodule

bind iir_lowpass_decimate_by_four ildf_checker u_ildf_checker (.*);
